// ----- design/ddo_pkg.sv -----
// Shared constants, types and helper functions for the differential drive odometry core.
`default_nettype none
package ddo_pkg;

  localparam int unsigned CordicIterationsDefault = 16;
  localparam int unsigned FracBitsDefault = 16;
  localparam logic [31:0] InvTwoTrackReset = 32'd32768;

  localparam logic signed [35:0] Q30Pi = 36'sd3373259426;
  localparam logic signed [35:0] Q30TwoPi = 36'sd6746518852;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] Q30Gain = 36'sd652032874;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpZero = 1'b1;

  // Wheel scale for a given number of fraction bits, worked out at elaboration.
  function automatic logic [31:0] wheel_scale(input int unsigned frac_bits);
    logic [63:0] num;
    begin
      num = (64'd628318 << (frac_bits + 16)) + 64'd1800000000;
      wheel_scale = 32'(num / 64'd3600000000);
    end
  endfunction

  // Reciprocal of 2*pi for estimating whole turns of an angle held in
  // Q(frac_bits): round(2^(66 - frac_bits) / Q30TwoPi), used with a shift of 36.
  function automatic logic [31:0] two_pi_recip(input int unsigned frac_bits);
    logic [63:0] num;
    begin
      num = (64'd1 << (66 - frac_bits)) + 64'd3373259426;
      two_pi_recip = 32'(num / 64'd6746518852);
    end
  endfunction

  function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0: atan_q30 = 36'sd843314857;
      5'd1: atan_q30 = 36'sd497837829;
      5'd2: atan_q30 = 36'sd263043837;
      5'd3: atan_q30 = 36'sd133525159;
      5'd4: atan_q30 = 36'sd67021687;
      5'd5: atan_q30 = 36'sd33543516;
      5'd6: atan_q30 = 36'sd16775851;
      5'd7: atan_q30 = 36'sd8388437;
      5'd8: atan_q30 = 36'sd4194283;
      5'd9: atan_q30 = 36'sd2097149;
      default: atan_q30 = 36'sd1 <<< (30 - idx);
    endcase
  endfunction

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the transaction and start delta scaling
    logic zero;      // clear pose and baselines
    logic mul_dist;  // form distance and heading change
    logic quot;      // estimate the whole turns in the angle
    logic remain;    // subtract the whole turns from the angle
    logic reduce;    // range reduction of the angle
    logic fold;      // fold into the right half plane
    logic rot;       // one CORDIC micro-rotation
    logic mul_xy;    // multiply distance by cos and sin
    logic commit;    // update pose registers
  } ddo_cmd_t;

  typedef struct packed {
    logic reduce_done;
    logic rot_done;
  } ddo_sts_t;

endpackage
`default_nettype wire

// ----- design/ddo_if.sv -----
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface ddo_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/ddo_ctrl.sv -----
// Sequencing state machine for the odometry core.
`default_nettype none
module ddo_ctrl import ddo_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_op_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ddo_sts_t sts_i,
  output ddo_cmd_t      cmd_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StScale  = 4'd1;
  localparam logic [3:0] StDist   = 4'd2;
  localparam logic [3:0] StReduce = 4'd3;
  localparam logic [3:0] StFold   = 4'd4;
  localparam logic [3:0] StRot    = 4'd5;
  localparam logic [3:0] StMul    = 4'd6;
  localparam logic [3:0] StCommit = 4'd7;
  localparam logic [3:0] StOut    = 4'd8;
  localparam logic [3:0] StQuot   = 4'd9;
  localparam logic [3:0] StRem    = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       zero_q, zero_d;
  logic       fire;

  // The result register may still hold an untaken result while new work runs,
  // but the commit waits until the result register is free.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign fire        = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    zero_d      = zero_q;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (fire) begin
          // Remember which kind of transaction runs; zeroing is applied at commit.
          zero_d = (in_op_i == OpZero);
          if (in_op_i == OpZero) begin
            state_d = StOut;
          end else begin
            cmd_o.load = 1'b1;
            state_d = StScale;
          end
        end
      end
      StScale: state_d = StDist;
      StDist: begin
        cmd_o.mul_dist = 1'b1;
        state_d = StQuot;
      end
      StQuot: begin
        cmd_o.quot = 1'b1;
        state_d = StRem;
      end
      StRem: begin
        cmd_o.remain = 1'b1;
        state_d = StReduce;
      end
      StReduce: begin
        cmd_o.reduce = 1'b1;
        if (sts_i.reduce_done) state_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        state_d = StRot;
      end
      StRot: begin
        cmd_o.rot = 1'b1;
        if (sts_i.rot_done) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul_xy = 1'b1;
        state_d = StCommit;
      end
      StCommit: state_d = StOut;
      StOut: begin
        if (!out_valid_d) begin
          cmd_o.commit = 1'b1;
          cmd_o.zero = zero_q;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      zero_q      <= zero_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/ddo_dp.sv -----
// Arithmetic datapath: delta scaling, heading change, CORDIC and pose registers.
`default_nettype none
module ddo_dp import ddo_pkg::*; #(
  parameter int unsigned CordicIterations = CordicIterationsDefault,
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ddo_cmd_t           cmd_i,
  output ddo_sts_t                sts_o,
  input  wire logic        [31:0] inv_two_track_i,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  output logic signed [31:0]      pose_x_o,
  output logic signed [31:0]      pose_y_o,
  output logic signed [31:0]      heading_o
);

  localparam logic signed [33:0] Scale = 34'(wheel_scale(FracBits));
  localparam logic signed [32:0] Recip = 33'(two_pi_recip(FracBits));
  localparam int unsigned ItW = $clog2(CordicIterations + 1);
  localparam logic signed [63:0] I32Max = 64'sd2147483647;
  localparam logic signed [63:0] I32Min = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > I32Max) sat32 = 32'sh7fffffff;
    else if (v < I32Min) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  logic signed [31:0] last_l_q, last_r_q, x_q, y_q, th_q;
  logic signed [32:0] dl_q, dr_q;
  logic signed [63:0] rl_q, rr_q;
  logic signed [31:0] d_q, dth_q;
  logic signed [32:0] ahalf_q;
  logic signed [23:0] quo_q;
  logic signed [35:0] ang_q;
  logic signed [35:0] cx_q, cy_q;
  logic               neg_q;
  logic [ItW-1:0]     it_q;
  logic signed [63:0] px_q, py_q;
  logic               scaled_q;

  // Stage 1: capture deltas (full 33-bit difference).
  // Stage 2: scale by the wheel constant (the 33 x 34 product is not split, as
  // Scale is narrow: product fits one multiplier).
  logic signed [66:0] pl, pr;
  assign pl = dl_q * Scale;
  assign pr = dr_q * Scale;

  logic signed [63:0] sum_lr, diff_lr;
  logic signed [31:0] diff_s;
  logic signed [65:0] tprod;
  logic signed [63:0] dth_w;
  assign sum_lr  = rl_q + rr_q;
  assign diff_lr = rr_q - rl_q;
  assign diff_s  = sat32(diff_lr);
  assign tprod   = 66'(diff_s) * $signed({34'd0, inv_two_track_i});
  assign dth_w   = 64'((tprod + (66'sd1 <<< (FracBits - 1))) >>> FracBits);

  // Whole turns are estimated by a reciprocal multiply to within one, and the
  // remainder is then brought into [-pi, pi] by the compare and add or subtract below.
  logic signed [65:0] qprod;
  logic signed [59:0] qt;
  logic signed [63:0] ang_full;
  assign qprod    = ahalf_q * Recip;
  assign qt       = quo_q * Q30TwoPi;
  assign ang_full = 64'(ahalf_q) <<< (30 - FracBits);

  logic signed [35:0] red_next;
  logic               red_done;
  always_comb begin
    red_next = ang_q;
    red_done = 1'b0;
    if (ang_q > Q30Pi) red_next = ang_q - Q30TwoPi;
    else if (ang_q < -Q30Pi) red_next = ang_q + Q30TwoPi;
    else red_done = 1'b1;
  end

  logic signed [35:0] ysh, xsh;
  assign ysh = cy_q >>> it_q;
  assign xsh = cx_q >>> it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      th_q     <= '0;
    end else if (cmd_i.commit) begin
      if (cmd_i.zero) begin
        last_l_q <= '0;
        last_r_q <= '0;
        x_q      <= '0;
        y_q      <= '0;
        th_q     <= '0;
      end else begin
        x_q  <= sat32(64'(x_q) + 64'((px_q + (64'sd1 <<< 29)) >>> 30));
        y_q  <= sat32(64'(y_q) + 64'((py_q + (64'sd1 <<< 29)) >>> 30));
        th_q <= sat32(64'(th_q) + 64'(dth_q));
      end
    end else if (cmd_i.load) begin
      last_l_q <= left_i;
      last_r_q <= right_i;
    end
  end

  // Baselines are replaced at load; the new positions only feed the deltas.
  always_ff @(posedge clk_i) begin
    scaled_q <= cmd_i.load;
    if (cmd_i.load) begin
      dl_q <= 33'(left_i) - 33'(last_l_q);
      dr_q <= 33'(right_i) - 33'(last_r_q);
    end
    if (scaled_q) begin
      rl_q <= 64'((pl + 67'sd32768) >>> 16);
      rr_q <= 64'((pr + 67'sd32768) >>> 16);
    end
    if (cmd_i.mul_dist) begin
      d_q     <= sat32(sum_lr >>> 1);
      dth_q   <= sat32(dth_w);
      ahalf_q <= 33'(th_q) + 33'(sat32(dth_w) >>> 1);
    end
    if (cmd_i.quot) quo_q <= 24'(qprod >>> 36);
    if (cmd_i.remain) ang_q <= 36'(ang_full - 64'(qt));
    if (cmd_i.reduce && !red_done) ang_q <= red_next;
    if (cmd_i.fold) begin
      cx_q <= Q30Gain;
      cy_q <= '0;
      it_q <= '0;
      neg_q <= 1'b0;
      if (ang_q > Q30HalfPi) begin
        ang_q <= ang_q - Q30Pi;
        neg_q <= 1'b1;
      end else if (ang_q < -Q30HalfPi) begin
        ang_q <= ang_q + Q30Pi;
        neg_q <= 1'b1;
      end
    end
    if (cmd_i.rot) begin
      it_q <= it_q + 1'b1;
      if (!ang_q[35]) begin
        cx_q  <= cx_q - ysh;
        cy_q  <= cy_q + xsh;
        ang_q <= ang_q - atan_q30(5'(it_q));
      end else begin
        cx_q  <= cx_q + ysh;
        cy_q  <= cy_q - xsh;
        ang_q <= ang_q + atan_q30(5'(it_q));
      end
    end
    if (cmd_i.mul_xy) begin
      px_q <= 64'(d_q) * 64'(neg_q ? -cx_q : cx_q);
      py_q <= 64'(d_q) * 64'(neg_q ? -cy_q : cy_q);
    end
  end

  assign sts_o.reduce_done = red_done;
  assign sts_o.rot_done    = (it_q == ItW'(CordicIterations - 1));
  assign pose_x_o  = x_q;
  assign pose_y_o  = y_q;
  assign heading_o = th_q;

endmodule
`default_nettype wire

// ----- design/differential_drive_odometry_core.sv -----
// Top level of the differential drive wheel odometry core.
`default_nettype none
// Each input transaction either zeroes the pose (op = 1) or advances it from
// the two absolute encoder positions (op = 0); every transaction yields exactly
// one result transaction with x, y and heading in signed Q16.16. An update
// scales the deltas, forms the distance and heading change, estimates and strips
// the whole turns off the angle, brings it into [-pi, pi], folds it, runs
// CordicIterations CORDIC micro-rotations, multiplies by cos/sin, commits and
// returns to idle. A zeroing transaction goes straight to commit. A new
// transaction is accepted only in idle. A result held back by the sink delays
// the commit of the next one. The user must write inv_two_track through
// cfg_we_i and cfg_wdata_i only while no transaction is in flight; the block
// itself does not enforce this.
module differential_drive_odometry_core import ddo_pkg::*; #(
  parameter int unsigned CordicIterations = CordicIterationsDefault,
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  ddo_if.sink              in_if,
  ddo_if.source            out_if
);

  logic [31:0] inv_two_track_q;
  ddo_cmd_t    cmd;
  ddo_sts_t    sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_two_track_q <= InvTwoTrackReset;
    end else if (cfg_we_i) begin
      inv_two_track_q <= cfg_wdata_i;
    end
  end

  // Input payload: {op, left_position, right_position}.
  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_if.data[64]),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Output payload: {pose_x_out, pose_y_out, heading_out}; the pose registers
  // are the result register and change only at commit.
  ddo_dp #(.CordicIterations(CordicIterations), .FracBits(FracBits)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .inv_two_track_i(inv_two_track_q),
    .left_i         (in_if.data[63:32]),
    .right_i        (in_if.data[31:0]),
    .pose_x_o       (out_if.data[95:64]),
    .pose_y_o       (out_if.data[63:32]),
    .heading_o      (out_if.data[31:0])
  );

  // A result held back by the sink must not change underneath it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(out_if.data))
    else $error("result changed while stalled");

  // No new transaction is taken while the CORDIC rotation runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rot |-> !in_if.ready)
    else $error("input accepted during rotation");

  // A commit never overwrites an untaken result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !out_if.valid || out_if.ready)
    else $error("commit over pending result");

endmodule
`default_nettype wire
